// ----- rtl/mvsm_pkg.sv -----
// Shared types and constants for the multi-voice sample mixer.
// No dependencies; the interfaces, front end, back end and top use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package mvsm_pkg;

    localparam int MAX_VOICES_DEF   = 8;
    localparam int SAMPLE_DEPTH_DEF = 16384;

    localparam int CMD_W    = 3;
    localparam int VOICE_W  = 3;
    localparam int SIDX_W   = 14;
    localparam int SMP_W    = 16;
    localparam int LEVEL_W  = 16;
    localparam int DELAY_W  = 24;
    localparam int LEN_W    = 15;
    localparam int MIX_W    = 20;
    localparam int FRAME_W  = 48;
    localparam int NV_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ACTIVE_W = 4;

    typedef logic [CMD_W-1:0] t_cmd_code;
    localparam t_cmd_code CMD_RENDER   = 3'd0;
    localparam t_cmd_code CMD_TARGET   = 3'd1;
    localparam t_cmd_code CMD_SCHEDULE = 3'd2;
    localparam t_cmd_code CMD_WRITE    = 3'd3;
    localparam t_cmd_code CMD_LENGTH   = 3'd4;
    localparam t_cmd_code CMD_CLEAR    = 3'd5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_ACTIVE_VOICES = 1'd0;
    localparam t_cfg_idx REG_RAMP_STEP     = 1'd1;

    localparam logic [LEVEL_W-1:0] ONE_Q15      = 16'h8000;
    localparam logic [LEVEL_W-1:0] RAMP_DEF     = 16'd328;
    localparam logic [FRAME_W-1:0] NEVER        = '1;
    localparam logic [MIX_W-1:0]   MIX_POS_LIM  = 20'h7FFFF;
    localparam logic [MIX_W-1:0]   MIX_NEG_LIM  = 20'h80000;

    // Decoded request as it sits in the queue between front and back.
    typedef struct packed {
        t_cmd_code                cmd;
        logic [VOICE_W-1:0]       voice;
        logic                     end_of_block;
        logic [SIDX_W-1:0]        sample_index;
        logic                     index_ok;
        logic signed [SMP_W-1:0]  left_sample;
        logic signed [SMP_W-1:0]  right_sample;
        logic [LEVEL_W-1:0]       target_level;
        logic [DELAY_W-1:0]       delay_frames;
        logic [LEN_W-1:0]         sample_length;
        logic                     bad_index;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage
`default_nettype wire

// ----- rtl/mvsm_cmd_if.sv -----
// Request channel: valid/ready handshake with the request fields.
// Uses mvsm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mvsm_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [mvsm_pkg::CMD_W-1:0]             cmd;
    logic [mvsm_pkg::VOICE_W-1:0]           voice;
    logic                                   end_of_block;
    logic [mvsm_pkg::SIDX_W-1:0]            sample_index;
    logic signed [mvsm_pkg::SMP_W-1:0]      left_sample;
    logic signed [mvsm_pkg::SMP_W-1:0]      right_sample;
    logic [mvsm_pkg::LEVEL_W-1:0]           target_level;
    logic [mvsm_pkg::DELAY_W-1:0]           delay_frames;
    logic [mvsm_pkg::LEN_W-1:0]             sample_length;

    modport source (output valid, cmd, voice, end_of_block, sample_index, left_sample,
                    right_sample, target_level, delay_frames, sample_length,
                    input ready);
    modport sink (input valid, cmd, voice, end_of_block, sample_index, left_sample,
                  right_sample, target_level, delay_frames, sample_length,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/mvsm_res_if.sv -----
// Result channel: valid/ready handshake with mix and status fields.
// Uses mvsm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mvsm_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [mvsm_pkg::MIX_W-1:0]  mix_left;
    logic signed [mvsm_pkg::MIX_W-1:0]  mix_right;
    logic                               is_mix;
    logic                               bad_index;

    modport source (output valid, mix_left, mix_right, is_mix, bad_index, input ready);
    modport sink (input valid, mix_left, mix_right, is_mix, bad_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/mvsm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mvsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/mvsm_front.sv -----
// Front end: takes requests, checks the voice index, clamps fields and
// queues decoded requests for the back end. Uses mvsm_pkg, mvsm_cmd_if.
`timescale 1ns / 1ps
`default_nettype none
module mvsm_front #(
    parameter int MAX_VOICES   = mvsm_pkg::MAX_VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [mvsm_pkg::ACTIVE_W-1:0] i_active_voices,
    mvsm_cmd_if.sink                           i_cmd,
    input  wire logic                          i_pop,
    output mvsm_pkg::t_head                    o_head
);
    localparam logic [mvsm_pkg::NV_W-1:0] MAXV = mvsm_pkg::NV_W'(MAX_VOICES);
    localparam logic [20:0] DEPTH_X = 21'(SAMPLE_DEPTH);

    mvsm_pkg::t_item r_q [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    logic [mvsm_pkg::NV_W-1:0] nv;
    logic                      push;
    mvsm_pkg::t_item           item;

    always_comb begin
        nv = ({1'b0, i_active_voices} > MAXV) ? MAXV : {1'b0, i_active_voices};
        item.cmd          = i_cmd.cmd;
        item.voice        = i_cmd.voice;
        item.end_of_block = i_cmd.end_of_block;
        item.sample_index = i_cmd.sample_index;
        item.index_ok     = {7'd0, i_cmd.sample_index} < DEPTH_X;
        item.left_sample  = i_cmd.left_sample;
        item.right_sample = i_cmd.right_sample;
        item.target_level = (i_cmd.target_level > mvsm_pkg::ONE_Q15) ?
                            mvsm_pkg::ONE_Q15 : i_cmd.target_level;
        item.delay_frames = i_cmd.delay_frames;
        item.sample_length = ({6'd0, i_cmd.sample_length} > DEPTH_X) ?
                             mvsm_pkg::LEN_W'(SAMPLE_DEPTH) : i_cmd.sample_length;
        item.bad_index    = (i_cmd.cmd >= mvsm_pkg::CMD_TARGET) &&
                            (i_cmd.cmd <= mvsm_pkg::CMD_CLEAR) &&
                            ({2'd0, i_cmd.voice} >= nv);
    end

    assign i_cmd.ready  = (r_count != 2'd2);
    assign push         = i_cmd.valid && i_cmd.ready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/mvsm_back.sv -----
// Back end: executes queued requests, holds voice state and the sample
// store, and mixes one voice per cycle. Uses mvsm_pkg, mvsm_ram, mvsm_res_if.
`timescale 1ns / 1ps
`default_nettype none
module mvsm_back #(
    parameter int MAX_VOICES   = mvsm_pkg::MAX_VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [mvsm_pkg::ACTIVE_W-1:0]  i_active_voices,
    input  wire logic [mvsm_pkg::LEVEL_W-1:0]   i_ramp_step,
    input  mvsm_pkg::t_head                     i_head,
    output logic                                o_pop,
    mvsm_res_if.source                          o_res
);
    localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int OFF_W  = $clog2(SAMPLE_DEPTH);
    localparam int ADDR_W = $clog2(MAX_VOICES * SAMPLE_DEPTH);
    localparam int ACC_W  = 33 + $clog2(MAX_VOICES + 1);
    localparam int Q_W    = ACC_W - 15;
    localparam logic [mvsm_pkg::NV_W-1:0] MAXV = mvsm_pkg::NV_W'(MAX_VOICES);
    localparam int FW = mvsm_pkg::FRAME_W;

    typedef enum logic [1:0] { S_IDLE, S_MIX, S_DONE } t_state;

    t_state r_state;
    logic [mvsm_pkg::NV_W-1:0]     r_vc;
    logic                          r_eob;
    logic                          r_p1;
    logic [mvsm_pkg::LEVEL_W-1:0]  r_p1_lvl;
    logic                          r_p2;
    logic signed [32:0]            r_prod_l;
    logic signed [32:0]            r_prod_r;
    logic signed [ACC_W-1:0]       r_acc_l;
    logic signed [ACC_W-1:0]       r_acc_r;
    logic [FW-1:0]                 r_fc;
    logic [FW-1:0]                 r_bs;
    logic [FW-1:0]                 r_vstart [MAX_VOICES];
    logic [FW-1:0]                 r_vnext  [MAX_VOICES];
    logic [mvsm_pkg::LEN_W-1:0]    r_vlen   [MAX_VOICES];
    logic [mvsm_pkg::LEVEL_W-1:0]  r_vlevel [MAX_VOICES];
    logic [mvsm_pkg::LEVEL_W-1:0]  r_vtarget[MAX_VOICES];
    logic                          r_out_valid;
    logic signed [mvsm_pkg::MIX_W-1:0] r_mix_l;
    logic signed [mvsm_pkg::MIX_W-1:0] r_mix_r;
    logic                          r_is_mix;
    logic                          r_bad;

    logic [mvsm_pkg::NV_W-1:0]     nv;
    mvsm_pkg::t_item               it;
    logic [4:0]                    cv5;
    logic [VIDX_W-1:0]             cvi;
    logic [VIDX_W-1:0]             vi;
    logic                          issuing;
    logic [FW-1:0]                 off;
    logic                          play;
    logic [ADDR_W-1:0]             raddr;
    logic [ADDR_W-1:0]             waddr;
    logic                          we;
    logic [31:0]                   rdata;
    logic signed [mvsm_pkg::MIX_W-1:0] fin_l;
    logic signed [mvsm_pkg::MIX_W-1:0] fin_r;
    logic [FW-1:0]                 fc_inc;

    function automatic logic [mvsm_pkg::MIX_W-1:0] finish(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [Q_W-1:0]   q;
        logic                    fits;
        t = a + ACC_W'(16384);
        q = Q_W'(t >>> 15);
        fits = (q[Q_W-1:mvsm_pkg::MIX_W-1] == '0) || (q[Q_W-1:mvsm_pkg::MIX_W-1] == '1);
        if (fits) begin
            return q[mvsm_pkg::MIX_W-1:0];
        end
        return q[Q_W-1] ? mvsm_pkg::MIX_NEG_LIM : mvsm_pkg::MIX_POS_LIM;
    endfunction

    function automatic logic [mvsm_pkg::LEVEL_W-1:0] ramp(
        input logic [mvsm_pkg::LEVEL_W-1:0] lvl,
        input logic [mvsm_pkg::LEVEL_W-1:0] tgt,
        input logic [mvsm_pkg::LEVEL_W-1:0] step
    );
        logic signed [17:0] d;
        logic signed [17:0] s;
        d = $signed({2'b00, tgt}) - $signed({2'b00, lvl});
        s = $signed({2'b00, step});
        if (d > s) begin
            return lvl + step;
        end else if (d < -s) begin
            return lvl - step;
        end
        return tgt;
    endfunction

    assign nv  = ({1'b0, i_active_voices} > MAXV) ? MAXV : {1'b0, i_active_voices};
    assign it  = i_head.item;
    assign cv5 = {2'b00, it.voice};
    assign cvi = cv5[VIDX_W-1:0];
    assign vi  = r_vc[VIDX_W-1:0];

    // when idle, take the next request as soon as the output register is free or being emptied
    assign o_pop = (r_state == S_IDLE) && i_head.valid && (!r_out_valid || o_res.ready);

    always_comb begin
        issuing = (r_state == S_MIX) && (r_vc < nv);
        off     = r_fc - r_vstart[vi];
        play    = issuing && !off[FW-1] && (off < {{(FW-mvsm_pkg::LEN_W){1'b0}}, r_vlen[vi]});
        raddr   = ADDR_W'(r_vc) * ADDR_W'(SAMPLE_DEPTH) + ADDR_W'(off[OFF_W-1:0]);
        waddr   = ADDR_W'(cvi) * ADDR_W'(SAMPLE_DEPTH) + ADDR_W'(it.sample_index);
        we      = o_pop && (it.cmd == mvsm_pkg::CMD_WRITE) && !it.bad_index && it.index_ok;
        fin_l   = finish(r_acc_l);
        fin_r   = finish(r_acc_r);
        fc_inc  = r_fc + FW'(1);
    end

    mvsm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VOICES * SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({it.right_sample, it.left_sample}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.mix_left  = r_mix_l;
    assign o_res.mix_right = r_mix_r;
    assign o_res.is_mix    = r_is_mix;
    assign o_res.bad_index = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_fc        <= '0;
            r_bs        <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < MAX_VOICES; v++) begin
                r_vstart[v]  <= '0;
                r_vnext[v]   <= mvsm_pkg::NEVER;
                r_vlen[v]    <= '0;
                r_vlevel[v]  <= '0;
                r_vtarget[v] <= '0;
            end
        end else begin
            if (r_out_valid && o_res.ready && !o_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_mix_l  <= '0;
                        r_mix_r  <= '0;
                        r_is_mix <= 1'b0;
                        r_bad    <= it.bad_index;
                        if (it.cmd == mvsm_pkg::CMD_RENDER) begin
                            r_out_valid <= 1'b0;
                            r_state <= S_MIX;
                            r_vc    <= '0;
                            r_eob   <= it.end_of_block;
                            r_acc_l <= '0;
                            r_acc_r <= '0;
                        end else begin
                            r_out_valid <= 1'b1;
                            if (!it.bad_index) begin
                                case (it.cmd)
                                    mvsm_pkg::CMD_TARGET: begin
                                        r_vtarget[cvi] <= it.target_level;
                                    end
                                    mvsm_pkg::CMD_SCHEDULE: begin
                                        r_vnext[cvi] <= r_fc + FW'(it.delay_frames);
                                    end
                                    mvsm_pkg::CMD_LENGTH: begin
                                        r_vlen[cvi] <= it.sample_length;
                                    end
                                    mvsm_pkg::CMD_CLEAR: begin
                                        r_vstart[cvi] <= '0;
                                        r_vlen[cvi]   <= '0;
                                        r_vlevel[cvi] <= '0;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                S_MIX: begin
                    // issue one voice read per cycle, multiply, then accumulate
                    if (issuing) begin
                        r_vc <= r_vc + 1'b1;
                    end
                    r_p1     <= play;
                    r_p1_lvl <= r_vlevel[vi];
                    r_p2     <= r_p1;
                    if (r_p1) begin
                        r_prod_l <= $signed(rdata[15:0]) * $signed({1'b0, r_p1_lvl});
                        r_prod_r <= $signed(rdata[31:16]) * $signed({1'b0, r_p1_lvl});
                    end
                    if (r_p2) begin
                        r_acc_l <= r_acc_l + ACC_W'(r_prod_l);
                        r_acc_r <= r_acc_r + ACC_W'(r_prod_r);
                    end
                    if (!issuing && !r_p1 && !r_p2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_mix_l     <= fin_l;
                    r_mix_r     <= fin_r;
                    r_is_mix    <= 1'b1;
                    r_bad       <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_fc        <= fc_inc;
                    if (r_eob) begin
                        r_bs <= fc_inc;
                        for (int v = 0; v < MAX_VOICES; v++) begin
                            if (mvsm_pkg::NV_W'(v) < nv) begin
                                r_vlevel[v] <= ramp(r_vlevel[v], r_vtarget[v], i_ramp_step);
                                if (r_bs >= r_vnext[v]) begin
                                    r_vstart[v] <= r_vnext[v];
                                    r_vnext[v]  <= mvsm_pkg::NEVER;
                                end
                            end
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/multi_voice_sample_mixer.sv -----
// Multi-voice stereo sample mixer with per-block volume ramp. A request is
// queued by the front end (two entries) and executed by the back end, one
// request at a time. A non-render request is executed at its pop. A render
// holds the back end for the pop, then reads the effective voice count
// (active_voices capped at MAX_VOICES) of voices one per cycle through the
// multiply-accumulate and the sample store's one read port, drains the read,
// multiply and accumulate stages, and then rounds and saturates. The back end
// takes the next request in the cycle its previous result leaves the output
// register, so with the output ready requests follow with no gap. No clearing
// pass: the sample store is undefined until written and must not be read
// before that.
// Depends on mvsm_pkg, mvsm_cmd_if, mvsm_res_if, mvsm_front, mvsm_back.
`timescale 1ns / 1ps
`default_nettype none
module multi_voice_sample_mixer #(
    parameter int MAX_VOICES   = mvsm_pkg::MAX_VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mvsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mvsm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    mvsm_cmd_if.sink                              i_cmd,
    mvsm_res_if.source                            o_res
);
    logic [mvsm_pkg::ACTIVE_W-1:0] r_active_voices;
    logic [mvsm_pkg::LEVEL_W-1:0]  r_ramp_step;
    mvsm_pkg::t_head               head;
    logic                          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_voices <= '0;
            r_ramp_step     <= mvsm_pkg::RAMP_DEF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvsm_pkg::REG_ACTIVE_VOICES: begin
                    r_active_voices <= i_cfg_wdata[mvsm_pkg::ACTIVE_W-1:0];
                end
                mvsm_pkg::REG_RAMP_STEP: begin
                    r_ramp_step <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    mvsm_front #(
        .MAX_VOICES   (MAX_VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active_voices (r_active_voices),
        .i_cmd           (i_cmd),
        .i_pop           (pop),
        .o_head          (head)
    );

    mvsm_back #(
        .MAX_VOICES   (MAX_VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active_voices (r_active_voices),
        .i_ramp_step     (r_ramp_step),
        .i_head          (head),
        .o_pop           (pop),
        .o_res           (o_res)
    );
endmodule
`default_nettype wire
